// ===== rtl/tcld_pkg.sv =====
// Shared types and constants for the ternary cluster label block.
// Holds the command/result structs, opcodes, error codes and FSM states.
// No dependencies.
`default_nettype none

package tcld_pkg;

	localparam int MAX_VERT_DEF = 32;
	localparam int VC_W         = 6;
	localparam int CNT_W        = 6;
	localparam int DIST_W       = 9;
	localparam int ROW_W        = 32;
	localparam int ROW_IW       = 5;
	localparam int VTX_W        = 5;
	localparam int LBL_W        = 2;

	localparam logic [VC_W-1:0]   VC_RESET = 6'd32;
	localparam logic [DIST_W-1:0] SUM_MAX  = 9'd511;

	typedef enum logic [1:0] {
		OP_ASSIGN = 2'd0,
		OP_READ   = 2'd1,
		OP_ROW    = 2'd2,
		OP_NOP    = 2'd3
	} tcld_op_t;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_LABEL = 2'd1;
	localparam logic [1:0] ERR_RANGE = 2'd2;

	localparam logic [LBL_W-1:0] LBL_NONE   = 2'd0;
	localparam logic [LBL_W-1:0] LBL_FIRST  = 2'd1;
	localparam logic [LBL_W-1:0] LBL_SECOND = 2'd2;
	localparam logic [LBL_W-1:0] LBL_THIRD  = 2'd3;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [VTX_W-1:0] vertex;
		logic [VTX_W-1:0] other_vertex;
		logic [LBL_W-1:0] new_label;
		logic [ROW_W-1:0] adjacency_row;
		logic             last_row;
	} tcld_in_t;

	typedef struct packed {
		logic [LBL_W-1:0]  label_of_vertex;
		logic              same_cluster;
		logic [CNT_W-1:0]  count_first;
		logic [CNT_W-1:0]  count_second;
		logic [CNT_W-1:0]  count_third;
		logic [CNT_W-1:0]  count_unclustered;
		logic [DIST_W-1:0] distance;
		logic              distance_done;
		logic [1:0]        error;
	} tcld_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_ROW,
		ST_OUT
	} tcld_state_t;

	// datapath -> sequencer
	typedef struct packed {
		logic row_go;   // row item with vertex in range, valid in ST_EVAL
		logic row_end;  // column counter reached vertex count
	} tcld_stat_t;

	// sequencer -> datapath
	typedef struct packed {
		logic accept;
		logic eval;
		logic step;
		logic finish;
	} tcld_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/tcld_label_mem.sv =====
// Label store: one 2-bit label per vertex, two registered read ports, one write port.
// Per-entry valid bits give the unclustered reset value; clear empties the store.
// Depends on tcld_pkg.
`default_nettype none

module tcld_label_mem
	import tcld_pkg::*;
#(
	parameter int DEPTH = MAX_VERT_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             clear,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [LBL_W-1:0] wdata,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [LBL_W-1:0] rdata_a,
	output logic      [LBL_W-1:0] rdata_b
);

	logic [LBL_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= valid_q[raddr_a] ? mem[raddr_a] : LBL_NONE;
		rdata_b <= valid_q[raddr_b] ? mem[raddr_b] : LBL_NONE;
	end

endmodule

`default_nettype wire

// ===== rtl/tcld_seq.sv =====
// Sequencer: idle, evaluate, column walk for row items, result cycle.
// Drives the datapath strobes; depends on tcld_pkg.
`default_nettype none

module tcld_seq
	import tcld_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire tcld_stat_t stat,
	output logic            busy,
	output tcld_ctrl_t      ctrl
);

	tcld_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = stat.row_go ? ST_ROW : ST_OUT;
			end
			ST_ROW: begin
				if (stat.row_end) state_d = ST_OUT;
			end
			ST_OUT: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy        = 1'b1;
		ctrl        = '0;
		unique case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				ctrl.accept = start;
			end
			ST_EVAL: begin
				ctrl.eval = 1'b1;
			end
			ST_ROW: begin
				ctrl.step = !stat.row_end;
			end
			ST_OUT: begin
				ctrl.finish = 1'b1;
			end
			default: busy = 1'b1;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/ternary_cluster_labels_disagreement.sv =====
// Flow: assign, read, no-op and rejected items pass from ST_EVAL straight to ST_OUT, where
// result_valid is raised and the result transfers; a row item for vertex v first walks
// columns v + 1 to n - 1 in ST_ROW (n = active vertex count), one column label compared
// per cycle through the label store's second read port.
// A new item is taken from the cycle after result_valid, never before the last result has
// transferred. Results cannot be stalled.
// Reset (arst_n low) is asynchronous: vertex_count 32, all labels unclustered, counts and sum 0.
`default_nettype none

module ternary_cluster_labels_disagreement
	import tcld_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERT_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire tcld_in_t        cmd,
	output logic                 busy,
	input  wire logic            cfg_wr_en,
	input  wire logic [VC_W-1:0] cfg_wr_data,
	output logic                 result_valid,
	output tcld_out_t            result
);

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int JW = $clog2(MAX_VERTICES + 1);
	localparam int CW = (JW > VTX_W) ? JW : VTX_W;

	tcld_ctrl_t ctrl;
	tcld_stat_t stat;

	// item registers
	tcld_op_t          op_q;
	logic [VTX_W-1:0]  v_q, w_q;
	logic [LBL_W-1:0]  lab_q;
	logic [ROW_W-1:0]  row_q;
	logic              last_q;

	// architectural state
	logic [VC_W-1:0]   vc_q;
	logic [CNT_W-1:0]  c1_q, c2_q, c3_q;
	logic [DIST_W-1:0] sum_q;

	// per-item working and result registers
	logic [JW-1:0]     j_q;
	logic [LBL_W-1:0]  li_q, lv_q;
	logic              same_q, done_q;
	logic [1:0]        err_q;

	logic [LBL_W-1:0]  rd_a, rd_b;
	logic [AW-1:0]     raddr_b;
	logic              mem_we;

	logic [JW-1:0]     n;
	logic              v_ok, w_ok;
	logic [1:0]        ev_err;
	logic              ev_asg, ev_same;
	logic [LBL_W-1:0]  ev_lv;
	logic [JW-1:0]     j_start, j_next;
	logic              joined, disagree;
	logic [7:0]        sum3, n8;

	// active vertex count: 0 acts as 1, anything above the store depth as the depth
	always_comb begin
		if (vc_q == '0) begin
			n = JW'(1);
		end else if (7'(vc_q) > 7'(MAX_VERTICES)) begin
			n = JW'(MAX_VERTICES);
		end else begin
			n = JW'(vc_q);
		end
	end

	assign v_ok = CW'(v_q) < CW'(n);
	assign w_ok = CW'(w_q) < CW'(n);

	always_comb begin
		ev_err  = ERR_NONE;
		ev_asg  = 1'b0;
		ev_same = 1'b0;
		unique case (op_q)
			OP_ASSIGN: begin
				if (lab_q == LBL_NONE) begin
					ev_err = ERR_LABEL;
				end else if (!v_ok) begin
					ev_err = ERR_RANGE;
				end else begin
					ev_asg = 1'b1;
				end
			end
			OP_READ: begin
				if (!v_ok || !w_ok) begin
					ev_err = ERR_RANGE;
				end else begin
					ev_same = (rd_a == rd_b);
				end
			end
			OP_ROW: begin
				if (!v_ok) ev_err = ERR_RANGE;
			end
			OP_NOP: ev_err = ERR_NONE;
			default: ev_err = ERR_NONE;
		endcase
		if (ev_asg) begin
			ev_lv = lab_q;
		end else if (v_ok) begin
			ev_lv = rd_a;
		end else begin
			ev_lv = LBL_NONE;
		end
	end

	assign stat.row_go  = (op_q == OP_ROW) && v_ok;
	assign stat.row_end = j_q >= n;

	assign j_start = JW'(v_q) + JW'(1);
	assign j_next  = j_q + JW'(1);

	// port B: second vertex at transfer, then the column walk one ahead of the compare
	always_comb begin
		priority if (ctrl.accept) begin
			raddr_b = AW'(cmd.other_vertex);
		end else if (ctrl.eval) begin
			raddr_b = AW'(j_start);
		end else begin
			raddr_b = AW'(j_next);
		end
	end

	assign joined   = (7'(j_q) < 7'(ROW_W)) && row_q[ROW_IW'(j_q)];
	assign disagree = (li_q == rd_b) ^ joined;
	assign mem_we   = ctrl.eval && ev_asg;

	tcld_label_mem #(
		.DEPTH(MAX_VERTICES),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (cfg_wr_en),
		.we     (mem_we),
		.waddr  (AW'(v_q)),
		.wdata  (lab_q),
		.raddr_a(AW'(cmd.vertex)),
		.raddr_b(raddr_b),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	tcld_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.busy  (busy),
		.ctrl  (ctrl)
	);

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			op_q   <= tcld_op_t'(cmd.opcode);
			v_q    <= cmd.vertex;
			w_q    <= cmd.other_vertex;
			lab_q  <= cmd.new_label;
			row_q  <= cmd.adjacency_row;
			last_q <= cmd.last_row;
		end
		if (ctrl.eval) begin
			li_q   <= rd_a;
			lv_q   <= ev_lv;
			same_q <= ev_same;
			err_q  <= ev_err;
			j_q    <= j_start;
		end else if (ctrl.step) begin
			j_q <= j_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q   <= VC_RESET;
			c1_q   <= '0;
			c2_q   <= '0;
			c3_q   <= '0;
			sum_q  <= '0;
			done_q <= 1'b0;
		end else if (cfg_wr_en) begin
			vc_q  <= cfg_wr_data;
			c1_q  <= '0;
			c2_q  <= '0;
			c3_q  <= '0;
			sum_q <= '0;
		end else begin
			if (mem_we) begin
				// same label in and out leaves the count unchanged
				c1_q <= c1_q + CNT_W'(lab_q == LBL_FIRST)  - CNT_W'(rd_a == LBL_FIRST);
				c2_q <= c2_q + CNT_W'(lab_q == LBL_SECOND) - CNT_W'(rd_a == LBL_SECOND);
				c3_q <= c3_q + CNT_W'(lab_q == LBL_THIRD)  - CNT_W'(rd_a == LBL_THIRD);
			end
			if (ctrl.eval) begin
				done_q <= stat.row_go && last_q;
			end
			if (ctrl.step && disagree && (sum_q != SUM_MAX)) begin
				sum_q <= sum_q + DIST_W'(1);
			end else if (ctrl.finish && done_q) begin
				sum_q <= '0;
			end
		end
	end

	assign sum3 = 8'(c1_q) + 8'(c2_q) + 8'(c3_q);
	assign n8   = 8'(n);

	assign result_valid = ctrl.finish;

	always_comb begin
		result.label_of_vertex   = lv_q;
		result.same_cluster      = same_q;
		result.count_first       = c1_q;
		result.count_second      = c2_q;
		result.count_third       = c3_q;
		result.count_unclustered = (n8 >= sum3) ? CNT_W'(n8 - sum3) : '0;
		result.distance          = sum_q;
		result.distance_done     = done_q;
		result.error             = err_q;
	end

`ifndef SYNTHESIS
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transfer taken but block not busy");
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !busy)
		else $error("block still busy after result");
	a_done_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.error != ERR_NONE) |-> !result.distance_done)
		else $error("pass total marked on a rejected item");
	a_same_on_err: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.error != ERR_NONE) |-> !result.same_cluster)
		else $error("same_cluster set on a rejected item");
	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.distance_done && !cfg_wr_en |=> sum_q == '0)
		else $error("sum not cleared after pass total");
`endif

endmodule

`default_nettype wire
